### hdl/angle_distance_frame_parser_defines.svh
// Assertion macros shared by the frame parser RTL.
// Used by the token queue and the parse engine; no other dependencies.
`ifndef ANGLE_DISTANCE_FRAME_PARSER_DEFINES_SVH
`define ANGLE_DISTANCE_FRAME_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define ADFP_ASSERT_HOLDS(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("adfp: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define ADFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("adfp: next-cycle check failed");

`endif

### hdl/adfp_pkg.sv
// Shared types and constants for the angle/distance frame parser.
// No dependencies; every other file but the assertion macro header uses it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package adfp_pkg;

    // Widths fixed by the port fields, plus the default value width and the queue depth
    localparam int CHAR_W          = 8;
    localparam int FIELD_W         = 32;
    localparam int STATUS_W        = 2;
    localparam int CFG_IDX_W       = 2;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int QUEUE_DEPTH     = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BEGIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DELIM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_END   = 2'd2;

    // Configuration reset values
    localparam logic [CHAR_W-1:0] BEGIN_RST = 8'd35;
    localparam logic [CHAR_W-1:0] DELIM_RST = 8'd58;
    localparam logic [CHAR_W-1:0] END_RST   = 8'd10;

    // Frame status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_DELIM = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD      = 2'd2;

    // Framing role of a byte (begin beats end beats delimiter)
    typedef logic [1:0] t_kind;
    localparam t_kind K_DATA  = 2'd0;
    localparam t_kind K_BEGIN = 2'd1;
    localparam t_kind K_END   = 2'd2;
    localparam t_kind K_DELIM = 2'd3;

    // Character class of a byte as seen by the number reader
    typedef logic [2:0] t_cls;
    localparam t_cls C_OTHER = 3'd0;
    localparam t_cls C_SPACE = 3'd1;
    localparam t_cls C_PLUS  = 3'd2;
    localparam t_cls C_MINUS = 3'd3;
    localparam t_cls C_DIGIT = 3'd4;

    // Classified byte handed from the front end to the parse engine
    typedef struct packed {
        t_kind      kind;
        t_cls       cls;
        logic [3:0] digit;
    } t_token;

endpackage

`default_nettype wire

### hdl/adfp_if.sv
// Channel interfaces of the frame parser: byte input, result output, config writes.
// Depends on adfp_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface adfp_byte_if;
    logic                         valid;
    logic                         ready;
    logic [adfp_pkg::CHAR_W-1:0]  rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface adfp_result_if;
    logic                          valid;
    logic                          ready;
    logic signed [adfp_pkg::FIELD_W-1:0] angle;
    logic signed [adfp_pkg::FIELD_W-1:0] distance;
    logic [adfp_pkg::STATUS_W-1:0] frame_status;

    modport source (output valid, output angle, output distance, output frame_status,
                    input ready);
    modport sink   (input valid, input angle, input distance, input frame_status,
                    output ready);
endinterface

interface adfp_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [adfp_pkg::CFG_IDX_W-1:0] index;
    logic [adfp_pkg::CHAR_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### hdl/angle_distance_frame_parser.sv
// Angle/distance frame parser top level: front end, token queue, parse engine.
// A result is posted once its end byte has passed the front end register, the token queue and the result register.
// Throughput: one byte per cycle while the result output is not stalled; the parse engine state is registered.
// Reset: synchronous active low; framing chars return to '#', ':', LF, held values to 0.
// Depends on adfp_pkg, adfp_if, adfp_front, adfp_queue and adfp_back.
`timescale 1ns / 1ps
`default_nettype none

module angle_distance_frame_parser #(
    parameter int VALUE_WIDTH = adfp_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    adfp_byte_if.sink      i_rx,
    adfp_cfg_if.sink       i_cfg,
    adfp_result_if.source  o_res
);

    adfp_pkg::t_token  w_front_tok, w_back_tok;
    logic              w_front_valid, w_front_ready;
    logic              w_back_valid, w_back_ready;

    // Classify bytes and hold configuration
    adfp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx        (i_rx),
        .i_cfg       (i_cfg),
        .o_tok       (w_front_tok),
        .o_tok_valid (w_front_valid),
        .i_tok_ready (w_front_ready)
    );

    // Decouple the two halves
    adfp_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_front_valid),
        .o_push_ready (w_front_ready),
        .i_push_tok   (w_front_tok),
        .o_pop_valid  (w_back_valid),
        .i_pop_ready  (w_back_ready),
        .o_pop_tok    (w_back_tok)
    );

    // Parse and post results
    adfp_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok       (w_back_tok),
        .i_tok_valid (w_back_valid),
        .o_tok_ready (w_back_ready),
        .o_res       (o_res)
    );

endmodule

`default_nettype wire

### hdl/adfp_front.sv
// Front end: holds the framing characters and classifies each received byte
// into a token. Depends on adfp_pkg and adfp_if.
`timescale 1ns / 1ps
`default_nettype none

module adfp_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    adfp_byte_if.sink             i_rx,
    adfp_cfg_if.sink              i_cfg,
    output adfp_pkg::t_token      o_tok,
    output logic                  o_tok_valid,
    input  wire logic             i_tok_ready
);

    logic [adfp_pkg::CHAR_W-1:0] r_begin, r_delim, r_end;
    logic                        r_valid, n_valid;
    adfp_pkg::t_token            r_tok, n_tok;
    logic                        w_rx_fire;
    logic                        w_digit, w_space;

    // Config writes are always taken
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_begin <= adfp_pkg::BEGIN_RST;
            r_delim <= adfp_pkg::DELIM_RST;
            r_end   <= adfp_pkg::END_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                adfp_pkg::REG_BEGIN: begin
                    r_begin <= i_cfg.data;
                end
                adfp_pkg::REG_DELIM: begin
                    r_delim <= i_cfg.data;
                end
                adfp_pkg::REG_END: begin
                    r_end <= i_cfg.data;
                end
                default: begin
                end
            endcase
        end
    end

    // Output stage frees up when the queue takes the held token
    assign i_rx.ready = !r_valid || i_tok_ready;
    assign w_rx_fire  = i_rx.valid && i_rx.ready;

    // Byte classification
    assign w_digit = (i_rx.rx_byte >= 8'h30) && (i_rx.rx_byte <= 8'h39);
    assign w_space = (i_rx.rx_byte == 8'h20) ||
                     ((i_rx.rx_byte >= 8'h09) && (i_rx.rx_byte <= 8'h0D));

    always_comb begin
        n_valid = r_valid && !i_tok_ready;
        n_tok   = r_tok;
        if (w_rx_fire) begin
            n_valid = 1'b1;
            // framing role, begin first, then end, then delimiter
            if (i_rx.rx_byte == r_begin) begin
                n_tok.kind = adfp_pkg::K_BEGIN;
            end else if (i_rx.rx_byte == r_end) begin
                n_tok.kind = adfp_pkg::K_END;
            end else if (i_rx.rx_byte == r_delim) begin
                n_tok.kind = adfp_pkg::K_DELIM;
            end else begin
                n_tok.kind = adfp_pkg::K_DATA;
            end
            // class for the number reader
            if (w_digit) begin
                n_tok.cls = adfp_pkg::C_DIGIT;
            end else if (w_space) begin
                n_tok.cls = adfp_pkg::C_SPACE;
            end else if (i_rx.rx_byte == 8'h2B) begin
                n_tok.cls = adfp_pkg::C_PLUS;
            end else if (i_rx.rx_byte == 8'h2D) begin
                n_tok.cls = adfp_pkg::C_MINUS;
            end else begin
                n_tok.cls = adfp_pkg::C_OTHER;
            end
            n_tok.digit = i_rx.rx_byte[3:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_tok <= n_tok;
    end

    assign o_tok       = r_tok;
    assign o_tok_valid = r_valid;

endmodule

`default_nettype wire

### hdl/adfp_queue.sv
// Short token queue between the front end and the parse engine.
// Depends on adfp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "angle_distance_frame_parser_defines.svh"

module adfp_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push_valid,
    output logic                   o_push_ready,
    input  wire adfp_pkg::t_token  i_push_tok,
    output logic                   o_pop_valid,
    input  wire logic              i_pop_ready,
    output adfp_pkg::t_token       o_pop_tok
);

    localparam int DEPTH = adfp_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    adfp_pkg::t_token   r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr, n_wr, r_rd, n_rd;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               w_push, w_pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_tok    = r_mem[r_rd];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    // Pointer and fill count update
    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (w_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (w_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
        if (w_push) begin
            r_mem[r_wr] <= i_push_tok;
        end
    end

    `ADFP_ASSERT_HOLDS(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(DEPTH))
    `ADFP_ASSERT_NEXT(a_count_up, i_clk, i_rst_n, w_push && !w_pop, r_count == $past(r_count) + 1'b1)
    `ADFP_ASSERT_NEXT(a_count_down, i_clk, i_rst_n, w_pop && !w_push, r_count == $past(r_count) - 1'b1)

endmodule

`default_nettype wire

### hdl/adfp_back.sv
// Parse engine: frame tracking, number reading, held values and result register.
// Depends on adfp_pkg, adfp_if and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "angle_distance_frame_parser_defines.svh"

module adfp_back #(
    parameter int VALUE_WIDTH = adfp_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire adfp_pkg::t_token  i_tok,
    input  wire logic              i_tok_valid,
    output logic                   o_tok_ready,
    adfp_result_if.source          o_res
);

    localparam int MW = VALUE_WIDTH;
    localparam int NW = VALUE_WIDTH + 4;

    // Number reader phases
    localparam logic [1:0] PH_SKIP   = 2'd0;
    localparam logic [1:0] PH_SIGN   = 2'd1;
    localparam logic [1:0] PH_DIGITS = 2'd2;
    localparam logic [1:0] PH_STOP   = 2'd3;

    logic                               r_in_frame, n_in_frame;
    logic                               r_delim_seen, n_delim_seen;
    logic [1:0]                         r_phase, n_phase;
    logic                               r_neg, n_neg;
    logic                               r_ovf, n_ovf;
    logic [MW-1:0]                      r_mag, n_mag;
    logic                               r_first_ok, n_first_ok;
    logic [MW-1:0]                      r_first_val, n_first_val;
    logic [MW-1:0]                      r_held_a, n_held_a;
    logic [MW-1:0]                      r_held_d, n_held_d;
    logic                               r_out_valid, n_out_valid;
    logic [adfp_pkg::FIELD_W-1:0]       r_out_a, n_out_a;
    logic [adfp_pkg::FIELD_W-1:0]       r_out_d, n_out_d;
    logic [adfp_pkg::STATUS_W-1:0]      r_out_st, n_out_st;

    logic                               w_take;
    logic                               w_num_valid;
    logic [MW-1:0]                      w_num_value;
    logic [NW-1:0]                      w_limit;
    logic [NW-1:0]                      w_next;
    logic                               w_is_digit;
    logic                               do_take;

    // A token is consumed whenever the result register can take a new result
    assign o_tok_ready = !r_out_valid || o_res.ready;
    assign w_take      = i_tok_valid && o_tok_ready;

    // Current number: validity, signed value, next magnitude and its limit
    assign w_num_valid = r_phase[1] && !r_ovf;
    assign w_num_value = r_neg ? (~r_mag + 1'b1) : r_mag;
    assign w_limit     = (NW'(1) << (MW - 1)) - NW'(!r_neg);
    assign w_next      = (NW'(r_mag) * NW'(10)) + NW'(i_tok.digit);
    assign w_is_digit  = (i_tok.cls == adfp_pkg::C_DIGIT);

    always_comb begin
        n_in_frame   = r_in_frame;
        n_delim_seen = r_delim_seen;
        n_phase      = r_phase;
        n_neg        = r_neg;
        n_ovf        = r_ovf;
        n_mag        = r_mag;
        n_first_ok   = r_first_ok;
        n_first_val  = r_first_val;
        n_held_a     = r_held_a;
        n_held_d     = r_held_d;
        n_out_valid  = r_out_valid && !o_res.ready;
        n_out_a      = r_out_a;
        n_out_d      = r_out_d;
        n_out_st     = r_out_st;
        do_take      = 1'b0;

        if (w_take) begin
            if (i_tok.kind == adfp_pkg::K_BEGIN) begin
                // open a frame; inside a frame the begin byte is skipped
                if (!r_in_frame) begin
                    n_in_frame   = 1'b1;
                    n_delim_seen = 1'b0;
                    n_first_ok   = 1'b0;
                    n_first_val  = '0;
                    n_phase      = PH_SKIP;
                    n_neg        = 1'b0;
                    n_ovf        = 1'b0;
                    n_mag        = '0;
                end
            end else if (!r_in_frame) begin
                // outside a frame: ignored
            end else if (i_tok.kind == adfp_pkg::K_END) begin
                // close the frame and post a result
                if (!r_delim_seen) begin
                    n_out_st = adfp_pkg::ST_NO_DELIM;
                end else if (r_first_ok && w_num_valid) begin
                    n_held_a = r_first_val;
                    n_held_d = w_num_value;
                    n_out_st = adfp_pkg::ST_OK;
                end else begin
                    n_out_st = adfp_pkg::ST_BAD;
                end
                n_out_valid  = 1'b1;
                n_out_a      = adfp_pkg::FIELD_W'(signed'(n_held_a));
                n_out_d      = adfp_pkg::FIELD_W'(signed'(n_held_d));
                n_in_frame   = 1'b0;
                n_delim_seen = 1'b0;
                n_first_ok   = 1'b0;
                n_first_val  = '0;
                n_phase      = PH_SKIP;
                n_neg        = 1'b0;
                n_ovf        = 1'b0;
                n_mag        = '0;
            end else if ((i_tok.kind == adfp_pkg::K_DELIM) && !r_delim_seen) begin
                // first delimiter: latch the angle outcome, restart the reader
                n_first_ok   = w_num_valid;
                n_first_val  = w_num_valid ? w_num_value : '0;
                n_delim_seen = 1'b1;
                n_phase      = PH_SKIP;
                n_neg        = 1'b0;
                n_ovf        = 1'b0;
                n_mag        = '0;
            end else begin
                // ordinary byte into the number reader
                case (r_phase)
                    PH_SKIP: begin
                        if (i_tok.cls == adfp_pkg::C_SPACE) begin
                            // leading whitespace
                        end else if ((i_tok.cls == adfp_pkg::C_PLUS) ||
                                     (i_tok.cls == adfp_pkg::C_MINUS)) begin
                            n_neg   = (i_tok.cls == adfp_pkg::C_MINUS);
                            n_phase = PH_SIGN;
                        end else if (w_is_digit) begin
                            do_take = 1'b1;
                        end else begin
                            n_ovf   = 1'b1;
                            n_phase = PH_STOP;
                        end
                    end
                    PH_SIGN: begin
                        if (w_is_digit) begin
                            do_take = 1'b1;
                        end else begin
                            n_ovf   = 1'b1;
                            n_phase = PH_STOP;
                        end
                    end
                    PH_DIGITS: begin
                        if (w_is_digit) begin
                            do_take = 1'b1;
                        end else begin
                            n_phase = PH_STOP;
                        end
                    end
                    default: begin
                    end
                endcase
                // accumulate one digit, flag overflow past the signed limit
                if (do_take) begin
                    if (r_ovf || (w_next > w_limit)) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_mag = w_next[MW-1:0];
                    end
                    n_phase = PH_DIGITS;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame   <= 1'b0;
            r_delim_seen <= 1'b0;
            r_phase      <= PH_SKIP;
            r_neg        <= 1'b0;
            r_ovf        <= 1'b0;
            r_mag        <= '0;
            r_first_ok   <= 1'b0;
            r_first_val  <= '0;
            r_held_a     <= '0;
            r_held_d     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_in_frame   <= n_in_frame;
            r_delim_seen <= n_delim_seen;
            r_phase      <= n_phase;
            r_neg        <= n_neg;
            r_ovf        <= n_ovf;
            r_mag        <= n_mag;
            r_first_ok   <= n_first_ok;
            r_first_val  <= n_first_val;
            r_held_a     <= n_held_a;
            r_held_d     <= n_held_d;
            r_out_valid  <= n_out_valid;
        end
        r_out_a  <= n_out_a;
        r_out_d  <= n_out_d;
        r_out_st <= n_out_st;
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.angle        = r_out_a;
    assign o_res.distance     = r_out_d;
    assign o_res.frame_status = r_out_st;

    `ADFP_ASSERT_HOLDS(a_ok_shows_held, i_clk, i_rst_n, r_out_valid && (r_out_st == adfp_pkg::ST_OK), (r_out_a == adfp_pkg::FIELD_W'(signed'(r_held_a))) && (r_out_d == adfp_pkg::FIELD_W'(signed'(r_held_d))))
    `ADFP_ASSERT_HOLDS(a_skip_clean, i_clk, i_rst_n, r_phase == PH_SKIP, (r_mag == '0) && !r_ovf && !r_neg)
    `ADFP_ASSERT_HOLDS(a_delim_in_frame, i_clk, i_rst_n, r_delim_seen, r_in_frame)

endmodule

`default_nettype wire
